FILE: rtl/are_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// are_pkg
// Shared types, codes and helpers of the accelerated rotary encoder counter.
// ---------------------------------------------------------------------------
package are_pkg;

    localparam int NUM_ENCODERS_DEF = 3;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W  = 32;
    localparam int TIME_W   = 32;
    localparam int SET_W    = 16;
    localparam int STEP_W   = 8;
    localparam int GAP_W    = 16;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEED   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DELIVERED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TURNING   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_GAP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SLOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FAST     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FASTEST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_IDLE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_IDLE    = 3'd7;

    typedef struct packed {
        logic [STEP_W-1:0] scan_interval;
        logic [GAP_W-1:0]  slow_gap;
        logic [GAP_W-1:0]  fast_gap;
        logic [STEP_W-1:0] step_slow;
        logic [STEP_W-1:0] step_fast;
        logic [STEP_W-1:0] step_fastest;
        logic [GAP_W-1:0]  read_idle;
        logic [GAP_W-1:0]  stale_idle;
    } t_cfg;

    typedef struct packed {
        logic scan;
        logic clear;
        logic set;
        logic seed;
    } t_chan_ctrl;

    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic               stale;
        logic               idle;
    } t_chan_stat;

    function automatic logic [STEP_W-1:0] step_size(input logic [TIME_W-1:0] gap,
                                                    input t_cfg cfg);
        logic [STEP_W-1:0] size;
        if (gap > {{(TIME_W-GAP_W){1'b0}}, cfg.slow_gap}) begin
            size = cfg.step_slow;
        end else if (gap > {{(TIME_W-GAP_W){1'b0}}, cfg.fast_gap}) begin
            size = cfg.step_fast;
        end else begin
            size = cfg.step_fastest;
        end
        return size;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/are_cfg_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// are_cfg_regs
// Configuration register file, written one register per beat.
// ---------------------------------------------------------------------------
module are_cfg_regs
    import are_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_interval <= 8'd1;
            r_cfg.slow_gap      <= 16'd10;
            r_cfg.fast_gap      <= 16'd5;
            r_cfg.step_slow     <= 8'd1;
            r_cfg.step_fast     <= 8'd10;
            r_cfg.step_fastest  <= 8'd50;
            r_cfg.read_idle     <= 16'd100;
            r_cfg.stale_idle    <= 16'd500;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCAN_INTERVAL: r_cfg.scan_interval <= i_cfg_data[STEP_W-1:0];
                REG_SLOW_GAP:      r_cfg.slow_gap      <= i_cfg_data[GAP_W-1:0];
                REG_FAST_GAP:      r_cfg.fast_gap      <= i_cfg_data[GAP_W-1:0];
                REG_STEP_SLOW:     r_cfg.step_slow     <= i_cfg_data[STEP_W-1:0];
                REG_STEP_FAST:     r_cfg.step_fast     <= i_cfg_data[STEP_W-1:0];
                REG_STEP_FASTEST:  r_cfg.step_fastest  <= i_cfg_data[STEP_W-1:0];
                REG_READ_IDLE:     r_cfg.read_idle     <= i_cfg_data[GAP_W-1:0];
                REG_STALE_IDLE:    r_cfg.stale_idle    <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/are_channel.sv
`default_nettype none
// ---------------------------------------------------------------------------
// are_channel
// State and step logic of one encoder: pin levels, count and step time.
// ---------------------------------------------------------------------------
module are_channel
    import are_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_chan_ctrl         i_ctrl,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_pin_a,
    input  wire logic               i_pin_b,
    input  wire logic [TIME_W-1:0]  i_now,
    input  wire logic [SET_W-1:0]   i_set_value,
    output t_chan_stat              o_stat
);

    logic               r_lvl_a;
    logic               r_lvl_b;
    logic [COUNT_W-1:0] r_total;
    logic [TIME_W-1:0]  r_last;

    logic [TIME_W-1:0]  gap;
    logic [STEP_W-1:0]  size_a;
    logic [STEP_W-1:0]  size_b;
    logic               a_step;
    logic               b_step;
    logic [COUNT_W-1:0] n_total;

    // Pin B sees the timestamp pin A has just written, so its gap is zero then.
    always_comb begin
        gap     = i_now - r_last;
        size_a  = step_size(gap, i_cfg);
        a_step  = (i_pin_a != r_lvl_a) && (i_pin_a != r_lvl_b);
        b_step  = (i_pin_b != r_lvl_b) && (i_pin_b != i_pin_a);
        size_b  = a_step ? i_cfg.step_fastest : size_a;
        n_total = r_total
                + (a_step ? {{(COUNT_W-STEP_W){1'b0}}, size_a} : '0)
                - (b_step ? {{(COUNT_W-STEP_W){1'b0}}, size_b} : '0);
    end

    assign o_stat.total = r_total;
    assign o_stat.stale = gap > {{(TIME_W-GAP_W){1'b0}}, i_cfg.stale_idle};
    assign o_stat.idle  = gap > {{(TIME_W-GAP_W){1'b0}}, i_cfg.read_idle};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_a <= 1'b0;
            r_lvl_b <= 1'b0;
            r_total <= '0;
            r_last  <= '0;
        end else if (i_ctrl.scan) begin
            r_lvl_a <= i_pin_a;
            r_lvl_b <= i_pin_b;
            r_total <= n_total;
            if (a_step || b_step) begin
                r_last <= i_now;
            end
        end else if (i_ctrl.seed) begin
            r_lvl_a <= i_pin_a;
            r_lvl_b <= i_pin_b;
            r_total <= '0;
            r_last  <= '0;
        end else if (i_ctrl.set) begin
            r_total <= {{(COUNT_W-SET_W){i_set_value[SET_W-1]}}, i_set_value};
        end else if (i_ctrl.clear) begin
            r_total <= '0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/accelerated_rotary_encoder_counter.sv
`default_nettype none
// ---------------------------------------------------------------------------
// accelerated_rotary_encoder_counter
// Multi-channel quadrature decoder with speed-dependent step size.
//
//  Channel   Handshake                    Payload
//  input     i_in_valid / o_in_stall      command, index, pins, set value, time
//  output    o_out_valid / i_out_stall    count_out, status
//  config    i_cfg_valid / o_cfg_ready    register index, write data
//
// Each beat passes an input register and a result register; one beat per
// cycle is accepted while a valid result is not stalled.
// Synchronous active-low reset clears all encoder state and loads defaults.
// A stalled result holds the whole pipeline and stalls the input side.
// ---------------------------------------------------------------------------
module accelerated_rotary_encoder_counter
    import are_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEF,
    localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [CMD_W-1:0]        i_command,
    input  wire logic [IDX_W-1:0]        i_encoder_index,
    input  wire logic [NUM_ENCODERS-1:0] i_pin_a_bits,
    input  wire logic [NUM_ENCODERS-1:0] i_pin_b_bits,
    input  wire logic signed [SET_W-1:0] i_set_value,
    input  wire logic [TIME_W-1:0]       i_current_time,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [COUNT_W-1:0]    o_count_out,
    output logic [STATUS_W-1:0]          o_status,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg cfg;

    logic                    en;
    logic                    go;
    logic                    r_iv;
    logic [CMD_W-1:0]        r_cmd;
    logic [IDX_W-1:0]        r_idx;
    logic [NUM_ENCODERS-1:0] r_pa;
    logic [NUM_ENCODERS-1:0] r_pb;
    logic [SET_W-1:0]        r_sv;
    logic [TIME_W-1:0]       r_now;
    logic [TIME_W-1:0]       r_last_scan;

    logic                    r_ov;
    logic [COUNT_W-1:0]      r_count;
    logic [STATUS_W-1:0]     r_status;

    logic                    idx_ok;
    logic                    scan_due;
    t_chan_stat              sel;
    logic [COUNT_W-1:0]      n_count;
    logic [STATUS_W-1:0]     n_status;
    logic                    read_clr;

    t_chan_ctrl              ctrl [NUM_ENCODERS];
    t_chan_stat              stat [NUM_ENCODERS];

    are_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_in_stall  = r_ov && i_out_stall;
    assign en          = !o_in_stall;
    assign go          = r_iv && en;
    assign o_out_valid = r_ov;
    assign o_count_out = r_count;
    assign o_status    = r_status;

    always_comb begin
        idx_ok   = {1'b0, r_idx} < (IDX_W+1)'(NUM_ENCODERS);
        scan_due = (r_now - r_last_scan) > {{(TIME_W-STEP_W){1'b0}}, cfg.scan_interval};
        sel      = idx_ok ? stat[r_idx] : '0;
        n_count  = '0;
        n_status = ST_DONE;
        read_clr = 1'b0;
        if (r_cmd == CMD_READ) begin
            if (!idx_ok) begin
                n_status = ST_STALE;
            end else if (sel.stale) begin
                n_status = ST_STALE;
                read_clr = 1'b1;
            end else if (sel.idle) begin
                n_count  = sel.total;
                n_status = ST_DELIVERED;
                read_clr = 1'b1;
            end else begin
                n_status = ST_TURNING;
            end
        end
    end

    for (genvar e = 0; e < NUM_ENCODERS; e++) begin : g_enc
        logic hit;
        assign hit = go && idx_ok && (r_idx == IDX_W'(e));
        assign ctrl[e].scan  = go && (r_cmd == CMD_SAMPLE) && scan_due;
        assign ctrl[e].clear = hit && ((r_cmd == CMD_CLEAR) || read_clr);
        assign ctrl[e].set   = hit && (r_cmd == CMD_SET);
        assign ctrl[e].seed  = hit && (r_cmd == CMD_SEED);

        are_channel u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl[e]),
            .i_cfg       (cfg),
            .i_pin_a     (r_pa[e]),
            .i_pin_b     (r_pb[e]),
            .i_now       (r_now),
            .i_set_value (r_sv),
            .o_stat      (stat[e])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv        <= 1'b0;
            r_ov        <= 1'b0;
            r_last_scan <= '0;
        end else if (en) begin
            r_iv <= i_in_valid;
            r_ov <= r_iv;
            if (r_iv && (r_cmd == CMD_SAMPLE) && scan_due) begin
                r_last_scan <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_in_valid) begin
            r_cmd <= i_command;
            r_idx <= i_encoder_index;
            r_pa  <= i_pin_a_bits;
            r_pb  <= i_pin_b_bits;
            r_sv  <= i_set_value;
            r_now <= i_current_time;
        end
        if (go) begin
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

endmodule
`default_nettype wire
